@@ rtl/core/scs1_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, scancode constants and the US layout ROM tables for the
// set-1 scancode translator. No dependencies.

package scs1_pkg;

    // Scancodes with a meaning of their own
    localparam logic [7:0] CODE_LSHIFT     = 8'h2A;
    localparam logic [7:0] CODE_RSHIFT     = 8'h36;
    localparam logic [7:0] CODE_LSHIFT_UP  = 8'hAA;
    localparam logic [7:0] CODE_RSHIFT_UP  = 8'hB6;
    localparam logic [7:0] CODE_CTRL       = 8'h1D;
    localparam logic [7:0] CODE_CTRL_UP    = 8'h9D;
    localparam logic [7:0] CODE_CAPS       = 8'h3A;
    localparam logic [7:0] CODE_BREAK_BIT  = 8'h80;
    localparam logic [7:0] CODE_KEY_C      = 8'h2E;
    localparam logic [7:0] CODE_KEY_BSLASH = 8'h2B;

    // Number of codes covered by the ROM tables
    localparam int unsigned KEY_COUNT = 58;

    localparam int unsigned PID_W  = 16;
    localparam int unsigned CHAR_W = 7;

    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'h7A;

    typedef enum logic [1:0]
    {
        KIND_CHAR = 2'd0,
        KIND_INTR = 2'd1,
        KIND_QUIT = 2'd2
    } kind_t;

    // Modifier flags carried from item to item
    typedef struct packed
    {
        logic shift_held;
        logic ctrl_held;
        logic caps_on;
    } mod_flags_t;

    // One translated item, hit low when the code gives no result
    typedef struct packed
    {
        logic              hit;
        kind_t             kind;
        logic [CHAR_W-1:0] char_code;
        logic [PID_W-1:0]  target_pid;
    } xlat_result_t;

    // Unshifted US layout
    function automatic logic [CHAR_W-1:0] rom_plain(input logic [5:0] idx);
        logic [CHAR_W-1:0] c;
        begin
            case (idx)
                6'd1:    c = 7'h1B; // escape
                6'd2:    c = 7'h31;
                6'd3:    c = 7'h32;
                6'd4:    c = 7'h33;
                6'd5:    c = 7'h34;
                6'd6:    c = 7'h35;
                6'd7:    c = 7'h36;
                6'd8:    c = 7'h37;
                6'd9:    c = 7'h38;
                6'd10:   c = 7'h39;
                6'd11:   c = 7'h30;
                6'd12:   c = 7'h2D;
                6'd13:   c = 7'h3D;
                6'd14:   c = 7'h08; // backspace
                6'd15:   c = 7'h09; // tab
                6'd16:   c = 7'h71;
                6'd17:   c = 7'h77;
                6'd18:   c = 7'h65;
                6'd19:   c = 7'h72;
                6'd20:   c = 7'h74;
                6'd21:   c = 7'h79;
                6'd22:   c = 7'h75;
                6'd23:   c = 7'h69;
                6'd24:   c = 7'h6F;
                6'd25:   c = 7'h70;
                6'd26:   c = 7'h5B;
                6'd27:   c = 7'h5D;
                6'd28:   c = 7'h0A; // enter
                6'd30:   c = 7'h61;
                6'd31:   c = 7'h73;
                6'd32:   c = 7'h64;
                6'd33:   c = 7'h66;
                6'd34:   c = 7'h67;
                6'd35:   c = 7'h68;
                6'd36:   c = 7'h6A;
                6'd37:   c = 7'h6B;
                6'd38:   c = 7'h6C;
                6'd39:   c = 7'h3B;
                6'd40:   c = 7'h27;
                6'd41:   c = 7'h60;
                6'd43:   c = 7'h5C;
                6'd44:   c = 7'h7A;
                6'd45:   c = 7'h78;
                6'd46:   c = 7'h63;
                6'd47:   c = 7'h76;
                6'd48:   c = 7'h62;
                6'd49:   c = 7'h6E;
                6'd50:   c = 7'h6D;
                6'd51:   c = 7'h2C;
                6'd52:   c = 7'h2E;
                6'd53:   c = 7'h2F;
                6'd55:   c = 7'h2A;
                6'd57:   c = 7'h20;
                default: c = 7'h00;
            endcase
            return c;
        end
    endfunction

    // Shifted US layout
    function automatic logic [CHAR_W-1:0] rom_shift(input logic [5:0] idx);
        logic [CHAR_W-1:0] c;
        begin
            case (idx)
                6'd1:    c = 7'h1B;
                6'd2:    c = 7'h21;
                6'd3:    c = 7'h40;
                6'd4:    c = 7'h23;
                6'd5:    c = 7'h24;
                6'd6:    c = 7'h25;
                6'd7:    c = 7'h5E;
                6'd8:    c = 7'h26;
                6'd9:    c = 7'h2A;
                6'd10:   c = 7'h28;
                6'd11:   c = 7'h29;
                6'd12:   c = 7'h5F;
                6'd13:   c = 7'h2B;
                6'd14:   c = 7'h08;
                6'd15:   c = 7'h09;
                6'd16:   c = 7'h51;
                6'd17:   c = 7'h57;
                6'd18:   c = 7'h45;
                6'd19:   c = 7'h52;
                6'd20:   c = 7'h54;
                6'd21:   c = 7'h59;
                6'd22:   c = 7'h55;
                6'd23:   c = 7'h49;
                6'd24:   c = 7'h4F;
                6'd25:   c = 7'h50;
                6'd26:   c = 7'h7B;
                6'd27:   c = 7'h7D;
                6'd28:   c = 7'h0A;
                6'd30:   c = 7'h41;
                6'd31:   c = 7'h53;
                6'd32:   c = 7'h44;
                6'd33:   c = 7'h46;
                6'd34:   c = 7'h47;
                6'd35:   c = 7'h48;
                6'd36:   c = 7'h4A;
                6'd37:   c = 7'h4B;
                6'd38:   c = 7'h4C;
                6'd39:   c = 7'h3A;
                6'd40:   c = 7'h22;
                6'd41:   c = 7'h7E;
                6'd43:   c = 7'h7C;
                6'd44:   c = 7'h5A;
                6'd45:   c = 7'h58;
                6'd46:   c = 7'h43;
                6'd47:   c = 7'h56;
                6'd48:   c = 7'h42;
                6'd49:   c = 7'h4E;
                6'd50:   c = 7'h4D;
                6'd51:   c = 7'h3C;
                6'd52:   c = 7'h3E;
                6'd53:   c = 7'h3F;
                6'd55:   c = 7'h2A;
                6'd57:   c = 7'h20;
                default: c = 7'h00;
            endcase
            return c;
        end
    endfunction

endpackage

@@ rtl/core/scs1_translate.sv @@
`timescale 1ns / 1ps
// Combinational translation of one scancode: modifier update, ctrl signal
// detection and ROM lookup. Depends on scs1_pkg.

module scs1_translate
(
    input  logic [7:0]                      code,
    input  scs1_pkg::mod_flags_t            flags,
    input  logic [scs1_pkg::PID_W-1:0]      pid,
    output scs1_pkg::mod_flags_t            flags_next,
    output scs1_pkg::xlat_result_t          res
);

    logic [5:0]                        key_idx;
    logic                              in_rom;
    logic [scs1_pkg::CHAR_W-1:0]       plain_c;
    logic [scs1_pkg::CHAR_W-1:0]       shift_c;
    logic                              is_letter;
    logic                              use_shift;
    logic                              sig_ok;

    // Look up both tables, pick by shift and caps
    assign key_idx   = code[5:0];
    assign in_rom    = (code < 8'(scs1_pkg::KEY_COUNT));
    assign plain_c   = scs1_pkg::rom_plain(key_idx);
    assign shift_c   = scs1_pkg::rom_shift(key_idx);
    assign is_letter = (plain_c >= scs1_pkg::CHAR_LOWER_A)
                       && (plain_c <= scs1_pkg::CHAR_LOWER_Z);
    assign use_shift = is_letter ? (flags.shift_held ^ flags.caps_on) : flags.shift_held;
    assign sig_ok    = flags.ctrl_held && (pid != '0);

    // Decode modifiers, signals and characters
    always_comb
    begin
        flags_next     = flags;
        res.hit        = 1'b0;
        res.kind       = scs1_pkg::KIND_CHAR;
        res.char_code  = '0;
        res.target_pid = '0;
        case (code)
            scs1_pkg::CODE_LSHIFT, scs1_pkg::CODE_RSHIFT:
            begin
                flags_next.shift_held = 1'b1;
            end
            scs1_pkg::CODE_LSHIFT_UP, scs1_pkg::CODE_RSHIFT_UP:
            begin
                flags_next.shift_held = 1'b0;
            end
            scs1_pkg::CODE_CTRL:
            begin
                flags_next.ctrl_held = 1'b1;
            end
            scs1_pkg::CODE_CTRL_UP:
            begin
                flags_next.ctrl_held = 1'b0;
            end
            scs1_pkg::CODE_CAPS:
            begin
                flags_next.caps_on = ~flags.caps_on;
            end
            default:
            begin
                if ((code & scs1_pkg::CODE_BREAK_BIT) == '0)
                begin
                    if (sig_ok && (code == scs1_pkg::CODE_KEY_C))
                    begin
                        res.hit        = 1'b1;
                        res.kind       = scs1_pkg::KIND_INTR;
                        res.target_pid = pid;
                    end
                    else if (sig_ok && (code == scs1_pkg::CODE_KEY_BSLASH))
                    begin
                        res.hit        = 1'b1;
                        res.kind       = scs1_pkg::KIND_QUIT;
                        res.target_pid = pid;
                    end
                    else if (in_rom && (plain_c != '0))
                    begin
                        res.hit       = 1'b1;
                        res.char_code = use_shift ? shift_c : plain_c;
                    end
                end
            end
        endcase
    end

endmodule

@@ rtl/core/scancode_set1_to_ascii.sv @@
`timescale 1ns / 1ps
// Top level of the set-1 scancode to ASCII translator: input register,
// modifier and process-id registers, result register. Depends on scs1_pkg
// and scs1_translate.

// Takes one PS/2 set-1 scancode byte per item and returns at most one
// result: an ASCII character (US layout) or, with ctrl held and a nonzero
// foreground_pid, an interrupt request for ctrl-C or a quit request for
// ctrl-backslash. Modifier make/break codes and other break codes yield no
// result. An item is held in the input register, where the table lookup
// and flag update happen, and then sits in the result register; a new
// item is taken every cycle while out_stall is low, so the throughput is
// one item per cycle. foreground_pid is written through cfg_valid/cfg_data
// (cfg_ready is always high) and must only change while no item is in
// flight.

module scancode_set1_to_ascii
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      scancode,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      result_kind,
    output logic [scs1_pkg::CHAR_W-1:0]     char_code,
    output logic [scs1_pkg::PID_W-1:0]      target_pid,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scs1_pkg::PID_W-1:0]      cfg_data
);

    logic                              in_full_reg;
    logic                              in_full_next;
    logic [7:0]                        code_reg;
    scs1_pkg::mod_flags_t              flags_reg;
    scs1_pkg::mod_flags_t              flags_next;
    logic [scs1_pkg::PID_W-1:0]        pid_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    scs1_pkg::kind_t                   kind_reg;
    logic [scs1_pkg::CHAR_W-1:0]       char_reg;
    logic [scs1_pkg::PID_W-1:0]        tpid_reg;
    scs1_pkg::xlat_result_t            res;
    logic                              out_free;
    logic                              advance;
    logic                              in_take;

    // Translate the held item
    scs1_translate u_translate
    (
        .code       (code_reg),
        .flags      (flags_reg),
        .pid        (pid_reg),
        .flags_next (flags_next),
        .res        (res)
    );

    // Handshake: advance when the result register is free or draining
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign advance   = in_full_reg & out_free;
    assign in_stall  = in_full_reg & ~out_free;
    assign in_take   = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;

    assign in_full_next   = in_take | (in_full_reg & ~advance);
    assign out_valid_next = out_free ? (advance & res.hit) : out_valid_reg;

    // Hold control state and modifier flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            pid_reg       <= '0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                flags_reg <= flags_next;
            end
            if (cfg_valid)
            begin
                pid_reg <= cfg_data;
            end
        end
    end

    // Capture the incoming item and the result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            code_reg <= scancode;
        end
        if (advance && res.hit)
        begin
            kind_reg <= res.kind;
            char_reg <= res.char_code;
            tpid_reg <= res.target_pid;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign char_code   = char_reg;
    assign target_pid  = tpid_reg;

`ifndef NO_ASSERTIONS
    // Signal results carry no character and a live process id
    a_signal_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind != scs1_pkg::KIND_CHAR))
        |-> ((char_code == '0) && (target_pid != '0)))
        else $error("signal result with bad payload");

    // Character results carry a character and no process id
    a_char_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind == scs1_pkg::KIND_CHAR))
        |-> ((char_code != '0) && (target_pid == '0)))
        else $error("character result with bad payload");

    // Input stalls only behind a held item and a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_full_reg && out_valid_reg && out_stall))
        else $error("input stalled without cause");

    // Flags move only when an item leaves the input register
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> $stable(flags_reg))
        else $error("modifier flags changed without an item");
`endif

endmodule

@@ verif/scancode_set1_to_ascii_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the set-1 scancode translator: random typing bursts and noise,
// a scoreboard predicting characters and ctrl signal requests. Depends on scs1_pkg and the RTL.

module scancode_set1_to_ascii_tb;

    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned PIPE_SLACK   = 4;
    localparam int unsigned PHASE_COUNT  = 6;
    localparam int unsigned PHASE_ITEMS  = 188;

    // One expected translation
    typedef struct
    {
        scs1_pkg::kind_t                 kind;
        logic [scs1_pkg::CHAR_W-1:0]     char_code;
        logic [scs1_pkg::PID_W-1:0]      target_pid;
    } key_event_t;

    // Tracks the modifier flags and the foreground pid, predicts every result
    class keymap_scoreboard;
        bit                              shift_held;
        bit                              ctrl_held;
        bit                              caps_on;
        logic [scs1_pkg::PID_W-1:0]      fg_pid;
        logic [scs1_pkg::CHAR_W-1:0]     plain_map [scs1_pkg::KEY_COUNT];
        logic [scs1_pkg::CHAR_W-1:0]     shift_map [scs1_pkg::KEY_COUNT];
        key_event_t                      expected_q [$];
        int unsigned                     failures;
        int unsigned                     chars_checked;
        int unsigned                     signals_checked;

        function new();
            shift_held      = 1'b0;
            ctrl_held       = 1'b0;
            caps_on         = 1'b0;
            fg_pid          = '0;
            failures        = 0;
            chars_checked   = 0;
            signals_checked = 0;
            // US layout, unshifted then shifted
            plain_map = '{7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
                          7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
                          7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
                          7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
                          7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
                          7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20};
            shift_map = '{7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
                          7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
                          7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
                          7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
                          7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
                          7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20};
        endfunction

        function void set_pid(logic [scs1_pkg::PID_W-1:0] value);
            fg_pid = value;
        endfunction

        // Update the flags for an accepted scancode and queue any result it gives
        function void note_scancode(logic [7:0] code);
            key_event_t                  ev;
            logic [scs1_pkg::CHAR_W-1:0] c;
            bit                          letter;
            if (code == scs1_pkg::CODE_LSHIFT || code == scs1_pkg::CODE_RSHIFT)
                shift_held = 1'b1;
            else if (code == scs1_pkg::CODE_LSHIFT_UP || code == scs1_pkg::CODE_RSHIFT_UP)
                shift_held = 1'b0;
            else if (code == scs1_pkg::CODE_CTRL)
                ctrl_held = 1'b1;
            else if (code == scs1_pkg::CODE_CTRL_UP)
                ctrl_held = 1'b0;
            else if (code == scs1_pkg::CODE_CAPS)
                caps_on = !caps_on;
            else if ((code & scs1_pkg::CODE_BREAK_BIT) != '0)
                return;
            else if (ctrl_held && fg_pid != '0 &&
                     (code == scs1_pkg::CODE_KEY_C || code == scs1_pkg::CODE_KEY_BSLASH))
            begin
                ev.kind       = (code == scs1_pkg::CODE_KEY_C) ? scs1_pkg::KIND_INTR
                                                               : scs1_pkg::KIND_QUIT;
                ev.char_code  = '0;
                ev.target_pid = fg_pid;
                expected_q.push_back(ev);
            end
            else if (code < scs1_pkg::KEY_COUNT && plain_map[code[5:0]] != '0)
            begin
                c      = plain_map[code[5:0]];
                letter = (c >= scs1_pkg::CHAR_LOWER_A && c <= scs1_pkg::CHAR_LOWER_Z);
                if (letter ? (shift_held ^ caps_on) : shift_held)
                    c = shift_map[code[5:0]];
                ev.kind       = scs1_pkg::KIND_CHAR;
                ev.char_code  = c;
                ev.target_pid = '0;
                expected_q.push_back(ev);
            end
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic [1:0] kind_bits, logic [scs1_pkg::CHAR_W-1:0] ch,
                                   logic [scs1_pkg::PID_W-1:0] pid);
            key_event_t ev;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: result_kind %0d char_code %0h target_pid %0h",
                       kind_bits, ch, pid);
                failures++;
                return;
            end
            ev = expected_q.pop_front();
            if (ev.kind == scs1_pkg::KIND_CHAR)
                chars_checked++;
            else
                signals_checked++;
            if (kind_bits !== ev.kind)
            begin
                $error("result_kind: expected %0d, got %0d", ev.kind, kind_bits);
                failures++;
            end
            if (ch !== ev.char_code)
            begin
                $error("char_code: expected %0h, got %0h", ev.char_code, ch);
                failures++;
            end
            if (pid !== ev.target_pid)
            begin
                $error("target_pid: expected %0h, got %0h", ev.target_pid, pid);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic [7:0]                      scancode  = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [1:0]                      result_kind;
    logic [scs1_pkg::CHAR_W-1:0]     char_code;
    logic [scs1_pkg::PID_W-1:0]      target_pid;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [scs1_pkg::PID_W-1:0]      cfg_data  = '0;

    keymap_scoreboard   sb = new();
    int unsigned        idle_pct     = 0;
    int unsigned        stall_pct    = 0;
    int unsigned        burst_items  = 0;
    int unsigned        codes_taken  = 0;
    int unsigned        quiet_cycles = 0;
    int unsigned        pid_writes   = 0;

    scancode_set1_to_ascii dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .scancode    (scancode),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .char_code   (char_code),
        .target_pid  (target_pid),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #2 clk = ~clk;

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Watch both channels, feed the scoreboard, end the run if nothing moves
    always @(posedge clk)
    begin
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.note_scancode(scancode);
                codes_taken++;
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                sb.check_result(result_kind, char_code, target_pid);
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready)
                moved = 1'b1;
            if (moved)
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    // Offer one scancode, after a random gap, and hold it until taken
    task automatic send_code(input logic [7:0] code);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        scancode <= code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_items++;
    endtask

    // Drop valid and let everything in flight come out
    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    task automatic write_pid(input logic [scs1_pkg::PID_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_pid(value);
        pid_writes++;
    endtask

    function automatic logic [7:0] pick_key();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 12)
            return $urandom_range(1) ? scs1_pkg::CODE_KEY_C : scs1_pkg::CODE_KEY_BSLASH;
        if (r < 90)
            return 8'($urandom_range(scs1_pkg::KEY_COUNT - 1));
        return 8'($urandom_range(8'h7F, 8'h3A));
    endfunction

    // Typing burst: modifiers down, a few keys, modifiers up; some raw noise
    task automatic random_burst();
        int unsigned n_keys;
        logic [7:0]  key;
        logic [7:0]  shift_code;
        bit          use_shift;
        bit          use_ctrl;
        if ($urandom_range(99) < 15)
        begin
            send_code(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(99) < 10)
            send_code(scs1_pkg::CODE_CAPS);
        use_shift  = ($urandom_range(99) < 35);
        use_ctrl   = ($urandom_range(99) < 25);
        shift_code = $urandom_range(1) ? scs1_pkg::CODE_LSHIFT : scs1_pkg::CODE_RSHIFT;
        if (use_shift)
            send_code(shift_code);
        if (use_ctrl)
            send_code(scs1_pkg::CODE_CTRL);
        n_keys = $urandom_range(6, 1);
        repeat (n_keys)
        begin
            key = pick_key();
            send_code(key);
            if ($urandom_range(1))
                send_code(key | scs1_pkg::CODE_BREAK_BIT);
        end
        if (use_ctrl)
            send_code(scs1_pkg::CODE_CTRL_UP);
        // Release with the other shift now and then: the flag is shared
        if (use_shift)
            send_code(($urandom_range(99) < 80) ? (shift_code | scs1_pkg::CODE_BREAK_BIT)
                      : ((shift_code == scs1_pkg::CODE_LSHIFT) ? scs1_pkg::CODE_RSHIFT_UP
                                                               : scs1_pkg::CODE_LSHIFT_UP));
    endtask

    initial
    begin
        logic [scs1_pkg::PID_W-1:0] pid_plan [PHASE_COUNT];
        int unsigned                idle_plan [PHASE_COUNT];
        int unsigned                stall_plan [PHASE_COUNT];
        logic [7:0]                 opening [$];
        logic [7:0]                 ctrl_seq [$];

        pid_plan   = '{16'hFFFF, 16'h0001, 16'h0000, 16'($urandom_range(65535, 1)),
                       16'hFFFF, 16'($urandom_range(65535))};
        idle_plan  = '{0, 88, 0, 11, 0, 11};
        stall_plan = '{0, 0, 88, 11, 0, 11};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset flags, pid zero: table edges, caps and shift interplay, caps release,
        // ctrl-C and ctrl-backslash with no foreground process, codes beyond the table
        opening = '{8'h00, 8'h01, 8'h1E, scs1_pkg::CODE_CAPS, 8'h1E, 8'h02,
                    scs1_pkg::CODE_LSHIFT, 8'h1E, 8'h02, scs1_pkg::CODE_LSHIFT_UP, 8'hBA,
                    8'h10, scs1_pkg::CODE_CAPS, scs1_pkg::CODE_RSHIFT,
                    scs1_pkg::CODE_KEY_BSLASH, scs1_pkg::CODE_RSHIFT_UP, scs1_pkg::CODE_CTRL,
                    scs1_pkg::CODE_KEY_C, scs1_pkg::CODE_CTRL_UP, 8'hFF, 8'h58};
        foreach (opening[i])
            send_code(opening[i]);

        // Signal requests, plus ordinary keys and shift while ctrl is held
        ctrl_seq = '{scs1_pkg::CODE_CTRL, scs1_pkg::CODE_KEY_C, scs1_pkg::CODE_KEY_BSLASH,
                     8'h10, scs1_pkg::CODE_LSHIFT, scs1_pkg::CODE_KEY_C,
                     scs1_pkg::CODE_LSHIFT_UP, scs1_pkg::CODE_CTRL_UP, scs1_pkg::CODE_KEY_C};

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain_pipe();
            write_pid(pid_plan[p]);
            idle_pct  = idle_plan[p];
            stall_pct = stall_plan[p];
            if (p == 0)
                foreach (ctrl_seq[i])
                    send_code(ctrl_seq[i]);
            burst_items = 0;
            while (burst_items < PHASE_ITEMS)
                random_burst();
        end

        drain_pipe();
        $display("Run took %0d scancodes; checked %0d characters and %0d signal requests",
                 codes_taken, sb.chars_checked, sb.signals_checked);
        $display("Covered %0d pid writes (zero and all-ones among them) under four idle patterns",
                 pid_writes);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
